@@ src/hhg_pkg.sv @@
package hhg_pkg;

  localparam int VOLT_W   = 16;
  localparam int RATE_W   = 24;
  localparam int STEADY_W = 16;
  localparam int Q30_W    = 31;
  localparam int FRAC_W   = 30;

  typedef logic signed [VOLT_W-1:0] voltage_t;
  typedef logic [RATE_W-1:0]        rate_t;
  typedef logic [STEADY_W-1:0]      steady_t;
  typedef logic [Q30_W-1:0]         q30_t;

  localparam logic [63:0] QONE64    = 64'h0000_0000_4000_0000;
  localparam logic [63:0] QCAP      = 64'h4000_0000_0000_0000;
  localparam q30_t        Q30_ONE   = 31'h4000_0000;
  localparam rate_t       RATE_MAX  = 24'hFF_FFFF;
  localparam logic [16:0] STEADY_ONE = 17'd32768;

  // exp(-x) pipeline shape
  localparam int SERIES_TERMS = 16;
  // e1^21 * 2^30 < 1, so any longer power chain has already reached zero
  localparam int POW_STAGES   = 21;
  // two for the argument split, two per series term, one for the sum
  localparam int EXP_LAT      = 2 + 2 * SERIES_TERMS + 1 + POW_STAGES;

  // exponent scales, Q7.8 raw units
  localparam int unsigned AM_DEN = 4 * 256;
  localparam int unsigned B_DEN  = 5 * 256;
  localparam int unsigned AH_DEN = 18 * 256;
  localparam int unsigned BN_DEN = 40 * 256;

  // rate divider shape
  localparam int NUM_W    = 52;
  localparam int DEN_W    = 37;
  localparam int QUO_W    = 64;
  localparam int STEADY_Q = 17;

  localparam int RATE_N = 6;
  localparam int PAIR_N = 3;
  localparam int RI_AM  = 0;
  localparam int RI_BM  = 1;
  localparam int RI_AH  = 2;
  localparam int RI_BH  = 3;
  localparam int RI_AN  = 4;
  localparam int RI_BN  = 5;

  typedef struct packed {
    logic [VOLT_W-1:0] dm;
    logic [VOLT_W-1:0] db;
    logic [VOLT_W-1:0] dn;
    logic am_pos;
    logic am_zero;
    logic xb_neg;
    logic xb_zero;
    logic an_pos;
    logic an_zero;
    logic ah_neg;
    logic bn_neg;
  } side_t;

  // truncated Taylor series of exp(-1), Q30: at r = 1.0 each term is the last one over i
  localparam logic [63:0] ET1  = QONE64;
  localparam logic [63:0] ET2  = ET1 / 2;
  localparam logic [63:0] ET3  = ET2 / 3;
  localparam logic [63:0] ET4  = ET3 / 4;
  localparam logic [63:0] ET5  = ET4 / 5;
  localparam logic [63:0] ET6  = ET5 / 6;
  localparam logic [63:0] ET7  = ET6 / 7;
  localparam logic [63:0] ET8  = ET7 / 8;
  localparam logic [63:0] ET9  = ET8 / 9;
  localparam logic [63:0] ET10 = ET9 / 10;
  localparam logic [63:0] ET11 = ET10 / 11;
  localparam logic [63:0] ET12 = ET11 / 12;
  localparam logic [63:0] ET13 = ET12 / 13;
  localparam logic [63:0] ET14 = ET13 / 14;
  localparam logic [63:0] ET15 = ET14 / 15;
  localparam logic [63:0] ET16 = ET15 / 16;

  localparam q30_t E1_Q30 = q30_t'(QONE64 - ET1 + ET2 - ET3 + ET4 - ET5 + ET6 - ET7 + ET8
                                   - ET9 + ET10 - ET11 + ET12 - ET13 + ET14 - ET15 + ET16);

endpackage

@@ src/hhg_if.sv @@
interface hhg_in_if import hhg_pkg::*; ();
  logic     valid;
  logic     ready;
  voltage_t voltage;

  modport source (output valid, output voltage, input ready);
  modport sink   (input valid, input voltage, output ready);
endinterface

interface hhg_out_if import hhg_pkg::*; ();
  logic    valid;
  logic    ready;
  rate_t   m_open_rate;
  rate_t   m_close_rate;
  rate_t   h_open_rate;
  rate_t   h_close_rate;
  rate_t   n_open_rate;
  rate_t   n_close_rate;
  steady_t m_steady;
  steady_t h_steady;
  steady_t n_steady;

  modport source (output valid, output m_open_rate, output m_close_rate,
                  output h_open_rate, output h_close_rate, output n_open_rate,
                  output n_close_rate, output m_steady, output h_steady,
                  output n_steady, input ready);
  modport sink   (input valid, input m_open_rate, input m_close_rate,
                  input h_open_rate, input h_close_rate, input n_open_rate,
                  input n_close_rate, input m_steady, input h_steady,
                  input n_steady, output ready);
endinterface

@@ src/hhg_exp.sv @@
module hhg_exp import hhg_pkg::*; #(
  parameter int unsigned DEN = AM_DEN
) (
  input  logic              clk,
  input  logic              en,
  input  logic [VOLT_W-1:0] num_i,
  output q30_t              e_o
);

  // DEN is 256 * K: split by K with a reciprocal, the low byte of the quotient
  // and a small table of remainder fractions make up the Q30 fraction
  localparam int unsigned K       = DEN >> 8;
  localparam int          KI_W    = $clog2(K);
  localparam int          WHOLE_W = $clog2((1 << VOLT_W) / DEN + 1);
  localparam int          TAB_W   = FRAC_W - 8;
  localparam int          RSH     = 2 * VOLT_W;
  localparam logic [RSH-1:0] RMUL = RSH'(((64'd1 << RSH) + 64'(K) - 64'd1) / 64'(K));

  logic [WHOLE_W-1:0]       wh_r   [0:SERIES_TERMS];
  logic [FRAC_W-1:0]        r_r    [0:SERIES_TERMS];
  q30_t                     term_r [0:SERIES_TERMS];
  logic signed [Q30_W+1:0]  sum_r  [0:SERIES_TERMS];
  logic [FRAC_W-1:0]        tx_r   [1:SERIES_TERMS];
  logic [WHOLE_W-1:0]       whm_r  [1:SERIES_TERMS];
  logic [FRAC_W-1:0]        rm_r   [1:SERIES_TERMS];
  logic signed [Q30_W+1:0]  summ_r [1:SERIES_TERMS];
  q30_t                     v_r    [0:POW_STAGES];
  logic [WHOLE_W-1:0]       wc_r   [0:POW_STAGES];

  logic [VOLT_W+RSH-1:0]    qprod;
  logic [VOLT_W-1:0]        qa;
  logic [VOLT_W-1:0]        qa_r;
  logic [VOLT_W-1:0]        na_r;
  logic [VOLT_W-1:0]        rfull;
  logic [KI_W-1:0]          ridx;
  logic [TAB_W-1:0]         ftab [0:K-1];

  for (genvar t = 0; t < K; t++) begin : g_ftab
    localparam logic [TAB_W-1:0] FV = TAB_W'((64'(t) << TAB_W) / 64'(K));
    assign ftab[t] = FV;
  end

  assign qprod = (VOLT_W+RSH)'(num_i) * (VOLT_W+RSH)'(RMUL);
  assign qa    = VOLT_W'(qprod >> RSH);
  assign rfull = na_r - VOLT_W'(qa_r * VOLT_W'(K));
  assign ridx  = KI_W'(rfull);

  // split into whole steps and a Q30 fraction
  always_ff @(posedge clk) begin
    if (en) begin
      qa_r      <= qa;
      na_r      <= num_i;
      wh_r[0]   <= WHOLE_W'(qa_r >> 8);
      r_r[0]    <= {qa_r[7:0], ftab[ridx]};
      term_r[0] <= Q30_ONE;
      sum_r[0]  <= $signed({2'b00, Q30_ONE});
    end
  end

  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_series
    // floor(x / k) by reciprocal multiply, exact for x below 2^30
    localparam int          DSH  = FRAC_W + $clog2(k);
    localparam logic [31:0] DMUL = 32'(((64'd1 << DSH) + 64'(k) - 64'd1) / 64'(k));
    logic [2*Q30_W-1:0] prod;
    logic [2*Q30_W-1:0] qp;
    q30_t               tn;

    assign prod = (2*Q30_W)'(term_r[k-1]) * (2*Q30_W)'(r_r[k-1]);
    assign qp   = (2*Q30_W)'(tx_r[k]) * (2*Q30_W)'(DMUL);
    assign tn   = q30_t'(qp >> DSH);

    always_ff @(posedge clk) begin
      if (en) begin
        tx_r[k]   <= FRAC_W'(prod >> FRAC_W);
        whm_r[k]  <= wh_r[k-1];
        rm_r[k]   <= r_r[k-1];
        summ_r[k] <= sum_r[k-1];
        wh_r[k]   <= whm_r[k];
        r_r[k]    <= rm_r[k];
        term_r[k] <= tn;
        if (k % 2 == 1) sum_r[k] <= summ_r[k] - $signed({2'b00, tn});
        else            sum_r[k] <= summ_r[k] + $signed({2'b00, tn});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]  <= (sum_r[SERIES_TERMS] < 0) ? '0 : q30_t'(sum_r[SERIES_TERMS]);
      wc_r[0] <= wh_r[SERIES_TERMS];
    end
  end

  // one multiply by exp(-1) per stage while whole steps remain
  for (genvar j = 1; j <= POW_STAGES; j++) begin : g_pow
    logic [2*Q30_W-1:0] pp;

    assign pp = (2*Q30_W)'(v_r[j-1]) * (2*Q30_W)'(E1_Q30);

    always_ff @(posedge clk) begin
      if (en) begin
        if (wc_r[j-1] != '0) begin
          v_r[j]  <= q30_t'(pp >> FRAC_W);
          wc_r[j] <= wc_r[j-1] - 1'b1;
        end else begin
          v_r[j]  <= v_r[j-1];
          wc_r[j] <= wc_r[j-1];
        end
      end
    end
  end

  assign e_o = (wc_r[POW_STAGES] != '0) ? '0 : v_r[POW_STAGES];

endmodule

@@ src/hhg_div.sv @@
module hhg_div import hhg_pkg::*; #(
  parameter int DW = DEN_W,
  parameter int QW = QUO_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] den_r [0:QW-1];
  logic [QW-1:0] num_r [0:QW-1];
  logic [QW-1:0] quo_r [0:QW-1];

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW-1:0] rp;
    logic [DW-1:0] dp;
    logic [QW-1:0] np;
    logic [QW-1:0] qp;
    logic [DW:0]   t;
    logic          ge;

    if (j == 0) begin : g_first
      assign rp = rem_i;
      assign dp = den_i;
      assign np = num_i;
      assign qp = '0;
    end else begin : g_next
      assign rp = rem_r[j-1];
      assign dp = den_r[j-1];
      assign np = num_r[j-1];
      assign qp = quo_r[j-1];
    end

    assign t  = {rp, np[QW-1]};
    assign ge = (t >= {1'b0, dp});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? DW'(t - {1'b0, dp}) : t[DW-1:0];
        den_r[j] <= dp;
        num_r[j] <= np << 1;
        quo_r[j] <= {qp[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

@@ src/hh_gating_rates_and_steady_state.sv @@
// Channel   Dir  Payload
// in_ch     in   voltage (signed Q7.8 mV)
// out_ch    out  six gate rates (Q8.16), three steady values (Q1.15)
//
// One item per cycle while out_ch is not stalled. The pipeline runs exp(-x) (the
// argument split, the series over 16 terms, the sum, then the powers of e^-1), the
// rate dividers (one quotient bit per stage), the steady-state dividers, plus five
// set-up and output registers.
// Reset clears only the valid bits. A stall at out_ch freezes the whole
// pipeline, so no transfer is lost or repeated.
module hh_gating_rates_and_steady_state import hhg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  hhg_in_if.sink    in_ch,
  hhg_out_if.source out_ch
);

  localparam int PIPE_LEN = EXP_LAT + 2 + QUO_W + 2 + STEADY_Q + 1;

  function automatic q30_t gate_gap(input q30_t e);
    return (e >= Q30_ONE) ? q30_t'(1) : q30_t'(Q30_ONE - e);
  endfunction

  function automatic q30_t at_least_one(input q30_t e);
    return (e == '0) ? q30_t'(1) : e;
  endfunction

  logic [PIPE_LEN-1:0] vld_r;
  logic                en;

  assign en          = !vld_r[PIPE_LEN-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_ch.valid};
    end
  end

  // exponent arguments
  logic signed [VOLT_W:0] xm, xb, xn, xh, xbn;
  logic [VOLT_W-1:0]      axh, axbn;
  side_t                  sd_in;

  always_comb begin
    xm   = (VOLT_W+1)'(in_ch.voltage) + 17'sd13824;
    xb   = (VOLT_W+1)'(in_ch.voltage) + 17'sd6912;
    xn   = (VOLT_W+1)'(in_ch.voltage) + 17'sd13312;
    xh   = (VOLT_W+1)'(in_ch.voltage) + 17'sd12800;
    xbn  = (VOLT_W+1)'(in_ch.voltage) + 17'sd14592;
    axh  = VOLT_W'((xh < 0) ? -xh : xh);
    axbn = VOLT_W'((xbn < 0) ? -xbn : xbn);
    sd_in.dm      = VOLT_W'((xm < 0) ? -xm : xm);
    sd_in.db      = VOLT_W'((xb < 0) ? -xb : xb);
    sd_in.dn      = VOLT_W'((xn < 0) ? -xn : xn);
    sd_in.am_pos  = (xm > 0);
    sd_in.am_zero = (xm == 0);
    sd_in.xb_neg  = (xb < 0);
    sd_in.xb_zero = (xb == 0);
    sd_in.an_pos  = (xn > 0);
    sd_in.an_zero = (xn == 0);
    sd_in.ah_neg  = (xh < 0);
    sd_in.bn_neg  = (xbn < 0);
  end

  side_t sd_r [0:EXP_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= sd_in;
      for (int k = 1; k < EXP_LAT; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  q30_t e_am, e_b, e_an, e_ah, e_bn;

  hhg_exp #(.DEN(AM_DEN)) u_exp_am (.clk, .en, .num_i(sd_in.dm), .e_o(e_am));
  hhg_exp #(.DEN(B_DEN))  u_exp_b  (.clk, .en, .num_i(sd_in.db), .e_o(e_b));
  hhg_exp #(.DEN(B_DEN))  u_exp_an (.clk, .en, .num_i(sd_in.dn), .e_o(e_an));
  hhg_exp #(.DEN(AH_DEN)) u_exp_ah (.clk, .en, .num_i(axh),      .e_o(e_ah));
  hhg_exp #(.DEN(BN_DEN)) u_exp_bn (.clk, .en, .num_i(axbn),     .e_o(e_bn));

  // quotient set-up: rate = round(N * 2^s / D)
  side_t              sdf;
  logic [46:0]        pm, pb, pn;
  logic [NUM_W-1:0]   n_nxt [0:RATE_N-1];
  logic [DEN_W-1:0]   d_nxt [0:RATE_N-1];
  logic [5:0]         s_nxt [0:RATE_N-1];

  assign sdf = sd_r[EXP_LAT-1];

  always_comb begin
    pm = 47'(sdf.dm) * 47'(sdf.am_pos ? Q30_ONE : e_am);
    pb = 47'(sdf.db) * 47'(sdf.xb_neg ? Q30_ONE : e_b);
    pn = 47'(sdf.dn) * 47'(sdf.an_pos ? Q30_ONE : e_an);

    n_nxt[RI_AM] = sdf.am_zero ? NUM_W'(32) : NUM_W'({pm, 5'b0});
    d_nxt[RI_AM] = sdf.am_zero ? DEN_W'(25) : DEN_W'(DEN_W'(100) * DEN_W'(gate_gap(e_am)));
    s_nxt[RI_AM] = sdf.am_zero ? 6'd32 : 6'd24;

    n_nxt[RI_BM] = sdf.xb_zero ? NUM_W'(7) : NUM_W'(NUM_W'(pb) * NUM_W'(7));
    d_nxt[RI_BM] = sdf.xb_zero ? DEN_W'(5) : DEN_W'(DEN_W'(25) * DEN_W'(gate_gap(e_b)));
    s_nxt[RI_BM] = sdf.xb_zero ? 6'd32 : 6'd24;

    n_nxt[RI_AN] = sdf.an_zero ? NUM_W'(4) : NUM_W'({pn, 2'b0});
    d_nxt[RI_AN] = sdf.an_zero ? DEN_W'(25) : DEN_W'(DEN_W'(125) * DEN_W'(gate_gap(e_an)));
    s_nxt[RI_AN] = sdf.an_zero ? 6'd32 : 6'd24;

    if (sdf.ah_neg) begin
      n_nxt[RI_AH] = NUM_W'(1) << 34;
      d_nxt[RI_AH] = DEN_W'(DEN_W'(125) * DEN_W'(at_least_one(e_ah)));
      s_nxt[RI_AH] = 6'd32;
    end else begin
      n_nxt[RI_AH] = NUM_W'({e_ah, 4'b0});
      d_nxt[RI_AH] = DEN_W'(125);
      s_nxt[RI_AH] = 6'd2;
    end

    n_nxt[RI_BH] = sdf.xb_neg ? NUM_W'({e_b, 2'b0}) : NUM_W'(1) << 32;
    d_nxt[RI_BH] = DEN_W'(Q30_ONE) + DEN_W'(e_b);
    s_nxt[RI_BH] = 6'd32;

    if (sdf.bn_neg) begin
      n_nxt[RI_BN] = NUM_W'(1) << 30;
      d_nxt[RI_BN] = DEN_W'({at_least_one(e_bn), 1'b0});
      s_nxt[RI_BN] = 6'd32;
    end else begin
      // 2e as a rounded division by one
      n_nxt[RI_BN] = NUM_W'(e_bn);
      d_nxt[RI_BN] = DEN_W'(1);
      s_nxt[RI_BN] = 6'd1;
    end
  end

  logic [NUM_W-1:0] nf_r [0:RATE_N-1];
  logic [DEN_W-1:0] df_r [0:RATE_N-1];
  logic [5:0]       sf_r [0:RATE_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < RATE_N; i++) begin
        nf_r[i] <= n_nxt[i];
        df_r[i] <= d_nxt[i];
        sf_r[i] <= s_nxt[i];
      end
    end
  end

  // align numerator: high part seeds the remainder, overflow means saturation
  logic [DEN_W-1:0]  remg_r [0:RATE_N-1];
  logic [QUO_W-1:0]  numg_r [0:RATE_N-1];
  logic [DEN_W-1:0]  deng_r [0:RATE_N-1];
  logic [RATE_N-1:0] ovf_r  [0:QUO_W];

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] hi;
    logic             ov;
    if (en) begin
      for (int i = 0; i < RATE_N; i++) begin
        hi = nf_r[i] >> (6'd63 - sf_r[i]);
        ov = (hi >= NUM_W'(df_r[i]));
        ovf_r[0][i] <= ov;
        remg_r[i]   <= ov ? '0 : DEN_W'(hi);
        numg_r[i]   <= QUO_W'({{(QUO_W-NUM_W){1'b0}}, nf_r[i]} << (7'(sf_r[i]) + 7'd1));
        deng_r[i]   <= df_r[i];
      end
      for (int k = 1; k <= QUO_W; k++) ovf_r[k] <= ovf_r[k-1];
    end
  end

  logic [QUO_W-1:0] quo_w [0:RATE_N-1];

  for (genvar i = 0; i < RATE_N; i++) begin : g_rate_div
    hhg_div #(.DW(DEN_W), .QW(QUO_W)) u_div (
      .clk,
      .en,
      .rem_i (remg_r[i]),
      .num_i (numg_r[i]),
      .den_i (deng_r[i]),
      .quo_o (quo_w[i])
    );
  end

  // Q32 rates with round half up
  logic [63:0] q32_r [0:RATE_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < RATE_N; i++) begin
        q32_r[i] <= ovf_r[QUO_W][i] ? QCAP : 64'((65'(quo_w[i]) + 65'd1) >> 1);
      end
    end
  end

  // Q8.16 rates and steady-state divider set-up
  logic [RATE_N-1:0][RATE_W-1:0] rq_r [0:STEADY_Q];
  logic [PAIR_N-1:0]             zr_r [0:STEADY_Q];
  logic [63:0]                   ss_r [0:PAIR_N-1];
  logic [63:0]                   sr_r [0:PAIR_N-1];
  logic [STEADY_Q-1:0]           sl_r [0:PAIR_N-1];

  always_ff @(posedge clk) begin
    logic [48:0] t16;
    logic [63:0] psum;
    if (en) begin
      for (int i = 0; i < RATE_N; i++) begin
        t16 = 49'((65'(q32_r[i]) + 65'd32768) >> 16);
        rq_r[0][i] <= (t16 > 49'(RATE_MAX)) ? RATE_MAX : t16[RATE_W-1:0];
      end
      for (int p = 0; p < PAIR_N; p++) begin
        psum = q32_r[2*p] + q32_r[2*p+1];
        ss_r[p]    <= psum;
        sr_r[p]    <= q32_r[2*p] >> 1;
        sl_r[p]    <= {q32_r[2*p][0], {(STEADY_Q-1){1'b0}}};
        zr_r[0][p] <= (psum == '0);
      end
      for (int k = 1; k <= STEADY_Q; k++) begin
        rq_r[k] <= rq_r[k-1];
        zr_r[k] <= zr_r[k-1];
      end
    end
  end

  logic [STEADY_Q-1:0] squo_w [0:PAIR_N-1];

  for (genvar p = 0; p < PAIR_N; p++) begin : g_steady_div
    hhg_div #(.DW(64), .QW(STEADY_Q)) u_div (
      .clk,
      .en,
      .rem_i (sr_r[p]),
      .num_i (sl_r[p]),
      .den_i (ss_r[p]),
      .quo_o (squo_w[p])
    );
  end

  // output register
  rate_t   out_rate_r [0:RATE_N-1];
  steady_t out_st_r   [0:PAIR_N-1];

  always_ff @(posedge clk) begin
    logic [STEADY_Q-1:0] rs;
    if (en) begin
      for (int i = 0; i < RATE_N; i++) out_rate_r[i] <= rq_r[STEADY_Q][i];
      for (int p = 0; p < PAIR_N; p++) begin
        rs = STEADY_Q'((18'(squo_w[p]) + 18'd1) >> 1);
        if (zr_r[STEADY_Q][p])     out_st_r[p] <= '0;
        else if (rs > STEADY_ONE)  out_st_r[p] <= STEADY_W'(STEADY_ONE);
        else                       out_st_r[p] <= rs[STEADY_W-1:0];
      end
    end
  end

  assign out_ch.valid        = vld_r[PIPE_LEN-1];
  assign out_ch.m_open_rate  = out_rate_r[RI_AM];
  assign out_ch.m_close_rate = out_rate_r[RI_BM];
  assign out_ch.h_open_rate  = out_rate_r[RI_AH];
  assign out_ch.h_close_rate = out_rate_r[RI_BH];
  assign out_ch.n_open_rate  = out_rate_r[RI_AN];
  assign out_ch.n_close_rate = out_rate_r[RI_BN];
  assign out_ch.m_steady     = out_st_r[0];
  assign out_ch.h_steady     = out_st_r[1];
  assign out_ch.n_steady     = out_st_r[2];

endmodule
